FILE: hdl/drt_pkg.sv
// Shared constants and types for the dense rank transform.
`timescale 1ns / 1ps

package drt_pkg;

    // Capacity of one set and the derived widths.
    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 7;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT_DUP,
        ST_SCAN_DUP,
        ST_INIT_CNT,
        ST_SCAN_CNT,
        ST_OUT
    } state_t;

    // Word that travels around the ring of cells.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid;
        logic                      rep;
    } nb_t;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] wr_idx;
        logic [CNT_W-1:0] count;
        logic             init_dup;
        logic             scan_dup;
        logic             init_cnt;
        logic             scan_cnt;
        logic [IDX_W-1:0] step;
        logic             shift_out;
    } cell_ctrl_t;

endpackage

FILE: hdl/drt_cell.sv
// One cell of the ring: holds one stored value, its duplicate mark and its rank.
`timescale 1ns / 1ps

module drt_cell (
    input  logic                        aclk,
    input  logic [drt_pkg::IDX_W-1:0]   cell_idx,
    input  drt_pkg::cell_ctrl_t         ctrl,
    input  drt_pkg::nb_t                nb_in,
    output drt_pkg::nb_t                nb_out,
    input  logic [drt_pkg::RANK_W-1:0]  rank_in,
    output logic [drt_pkg::RANK_W-1:0]  rank_out
);

    logic signed [drt_pkg::VALUE_W-1:0] value_reg;
    drt_pkg::nb_t                       travel_reg;
    logic                               rep_reg;
    logic [drt_pkg::RANK_W-1:0]         rank_reg;
    logic                               own_valid;
    logic                               init;
    logic                               earlier;

    // The cell holds a kept item when its position is below the item count.
    assign own_valid = (drt_pkg::CNT_W'(cell_idx) < ctrl.count);
    assign init      = ctrl.init_dup | ctrl.init_cnt;

    // After a shift distance of step, the visiting word came from an earlier
    // position exactly when it did not wrap around the ring.
    assign earlier = (ctrl.step <= cell_idx);

    // At the start of a pass the cell launches its own value; otherwise it
    // forwards the word it is currently looking at.
    always_comb begin
        if (init) begin
            nb_out.value = value_reg;
            nb_out.valid = own_valid;
            nb_out.rep   = rep_reg;
        end else begin
            nb_out = travel_reg;
        end
    end

    assign rank_out = rank_reg;

    // Stored value, written once per set at its arrival position; load data
    // arrives on the ring input's value lanes.
    always_ff @(posedge aclk) begin
        if (ctrl.load && (ctrl.wr_idx == cell_idx)) begin
            value_reg <= nb_in.value;
        end
    end

    // Visiting word moves one cell per cycle during both passes.
    always_ff @(posedge aclk) begin
        if (init || ctrl.scan_dup || ctrl.scan_cnt) begin
            travel_reg <= nb_in;
        end
    end

    // A value is the representative of its group unless an earlier equal one exists.
    always_ff @(posedge aclk) begin
        if (ctrl.init_dup) begin
            rep_reg <= 1'b1;
        end else if (ctrl.scan_dup && travel_reg.valid && earlier
                     && (travel_reg.value == value_reg)) begin
            rep_reg <= 1'b0;
        end
    end

    // Rank starts at one and adds one per distinct smaller value, then the ranks shift out.
    always_ff @(posedge aclk) begin
        if (ctrl.init_cnt) begin
            rank_reg <= drt_pkg::RANK_W'(1);
        end else if (ctrl.scan_cnt && travel_reg.valid && travel_reg.rep
                     && (travel_reg.value < value_reg)) begin
            rank_reg <= rank_reg + drt_pkg::RANK_W'(1);
        end else if (ctrl.shift_out) begin
            rank_reg <= rank_in;
        end
    end

endmodule

FILE: hdl/drt_ctrl.sv
// Controller: item counting, pass sequencing and result handshake.
`timescale 1ns / 1ps

module drt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 m_tlast,
    output logic                 m_tuser,
    output drt_pkg::cell_ctrl_t  ctrl
);

    drt_pkg::state_t             state_reg, state_next;
    logic [drt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        dropped_reg, dropped_next;
    logic [drt_pkg::IDX_W-1:0]   step_reg, step_next;
    logic [drt_pkg::CNT_W-1:0]   out_idx_reg, out_idx_next;
    logic                        in_word;
    logic                        out_word;
    logic                        room;
    logic                        step_done;
    logic                        out_last;

    assign in_word   = s_tvalid && (state_reg == drt_pkg::ST_LOAD);
    assign out_word  = m_tready && (state_reg == drt_pkg::ST_OUT);
    assign room      = (count_reg < drt_pkg::CNT_W'(drt_pkg::MAX_ITEMS));
    assign step_done = (step_reg == drt_pkg::IDX_W'(drt_pkg::MAX_ITEMS - 1));
    assign out_last  = ((out_idx_reg + drt_pkg::CNT_W'(1)) == count_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            drt_pkg::ST_LOAD: begin
                if (in_word && s_tlast) state_next = drt_pkg::ST_INIT_DUP;
            end
            drt_pkg::ST_INIT_DUP: state_next = drt_pkg::ST_SCAN_DUP;
            drt_pkg::ST_SCAN_DUP: begin
                if (step_done) state_next = drt_pkg::ST_INIT_CNT;
            end
            drt_pkg::ST_INIT_CNT: state_next = drt_pkg::ST_SCAN_CNT;
            drt_pkg::ST_SCAN_CNT: begin
                if (step_done) state_next = drt_pkg::ST_OUT;
            end
            drt_pkg::ST_OUT: begin
                if (out_word && out_last) state_next = drt_pkg::ST_LOAD;
            end
            default: state_next = drt_pkg::ST_LOAD;
        endcase
    end

    // Outputs and cell control.
    always_comb begin
        s_tready       = (state_reg == drt_pkg::ST_LOAD);
        m_tvalid       = (state_reg == drt_pkg::ST_OUT);
        m_tlast        = out_last;
        m_tuser        = dropped_reg;
        ctrl.load      = in_word && room;
        ctrl.wr_idx    = count_reg[drt_pkg::IDX_W-1:0];
        ctrl.count     = count_reg;
        ctrl.init_dup  = (state_reg == drt_pkg::ST_INIT_DUP);
        ctrl.scan_dup  = (state_reg == drt_pkg::ST_SCAN_DUP);
        ctrl.init_cnt  = (state_reg == drt_pkg::ST_INIT_CNT);
        ctrl.scan_cnt  = (state_reg == drt_pkg::ST_SCAN_CNT);
        ctrl.step      = step_reg;
        ctrl.shift_out = out_word;
    end

    // Counters and the overflow flag.
    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        step_next    = step_reg;
        out_idx_next = out_idx_reg;
        if (in_word) begin
            if (room) begin
                count_next = count_reg + drt_pkg::CNT_W'(1);
            end else begin
                dropped_next = 1'b1;
            end
        end
        if ((state_reg == drt_pkg::ST_INIT_DUP) || (state_reg == drt_pkg::ST_INIT_CNT)) begin
            step_next = drt_pkg::IDX_W'(1);
        end else begin
            step_next = step_reg + drt_pkg::IDX_W'(1);
        end
        if (state_reg == drt_pkg::ST_SCAN_CNT) begin
            out_idx_next = '0;
        end else if (out_word) begin
            out_idx_next = out_idx_reg + drt_pkg::CNT_W'(1);
            if (out_last) begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= drt_pkg::ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            step_reg    <= '0;
            out_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            step_reg    <= step_next;
            out_idx_reg <= out_idx_next;
        end
    end

endmodule

FILE: hdl/dense_rank_transform_top.sv
// Dense rank transform: loads a set of values, ranks them in a ring of cells.
// Loading takes one word per cycle while s_tvalid is high.
// After the marked last word, two passes run around the ring of MAX_ITEMS cells,
// first the duplicate-marking pass and then the rank-counting pass.
// Ranks then leave one word per cycle in arrival order, paced by m_tready.
// aresetn is synchronous and active low; it clears the controller's state, counters and flag only.
`timescale 1ns / 1ps

module dense_rank_transform_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] rank, [7] zero
    output logic        m_tlast,   // last_out
    output logic        m_tuser    // [0] overflow
);

    drt_pkg::cell_ctrl_t         ctrl;
    drt_pkg::nb_t                nb      [drt_pkg::MAX_ITEMS];
    drt_pkg::nb_t                nb_in   [drt_pkg::MAX_ITEMS];
    logic [drt_pkg::RANK_W-1:0]  rank    [drt_pkg::MAX_ITEMS];

    drt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .ctrl     (ctrl)
    );

    // Ring of cells; while loading, the input value rides on the ring input lanes.
    for (genvar i = 0; i < drt_pkg::MAX_ITEMS; i++) begin : g_cell
        always_comb begin
            nb_in[i] = nb[(i + drt_pkg::MAX_ITEMS - 1) % drt_pkg::MAX_ITEMS];
            if (ctrl.load) begin
                nb_in[i].value = $signed(s_tdata);
            end
        end

        if (i == drt_pkg::MAX_ITEMS - 1) begin : g_end
            drt_cell u_cell (
                .aclk     (aclk),
                .cell_idx (drt_pkg::IDX_W'(i)),
                .ctrl     (ctrl),
                .nb_in    (nb_in[i]),
                .nb_out   (nb[i]),
                .rank_in  ({drt_pkg::RANK_W{1'b0}}),
                .rank_out (rank[i])
            );
        end else begin : g_mid
            drt_cell u_cell (
                .aclk     (aclk),
                .cell_idx (drt_pkg::IDX_W'(i)),
                .ctrl     (ctrl),
                .nb_in    (nb_in[i]),
                .nb_out   (nb[i]),
                .rank_in  (rank[i + 1]),
                .rank_out (rank[i])
            );
        end
    end

    // While results are sent, the first cell holds the rank of the next word to send.
    assign m_tdata = {1'b0, rank[0]};

    // Input and output sides are never open at the same time.
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    // A set's results continue until the marked final word.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("result stream stopped before its last word");

    // The marked last input closes the input side for the ranking passes.
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input stayed open after the last word");

    // A dense rank is never zero.
    a_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] != 7'd0))
        else $error("zero rank sent");

endmodule
